>>> rtl/linked_queue_with_remove_top_defines.svh
// ----------------------------------------------------------------------------
// linked queue assertion macros
// property check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef LINKED_QUEUE_WITH_REMOVE_TOP_DEFINES_SVH
`define LINKED_QUEUE_WITH_REMOVE_TOP_DEFINES_SVH

`ifndef SYNTH
`define LQR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lqr assertion failed");
`define LQR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  `LQR_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))
`else
`define LQR_ASSERT(lbl, clk, rst_n, prop)
`define LQR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/lqr_pkg.sv
// ----------------------------------------------------------------------------
// lqr_pkg
// shared types and constants of the linked queue with remove
// ----------------------------------------------------------------------------
package lqr_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int OUT_W           = 32;
  localparam int MODE_W          = 3;
  localparam int STATUS_W        = 3;

  typedef logic [MODE_W-1:0] lqr_mode_t;

  localparam lqr_mode_t MODE_PUSH_TAIL = 3'd0;
  localparam lqr_mode_t MODE_PUSH_HEAD = 3'd1;
  localparam lqr_mode_t MODE_POP       = 3'd2;
  localparam lqr_mode_t MODE_REMOVE    = 3'd3;
  localparam lqr_mode_t MODE_CLEAR     = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_ZERO      = 3'd4
  } lqr_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_POP_NEXT,
    S_POP_VAL,
    S_WALK_NEXT,
    S_WALK_CMP,
    S_DONE
  } lqr_state_e;

  typedef struct packed {
    logic        valid;
    lqr_status_e status;
  } lqr_res_t;

endpackage

>>> rtl/lqr_ram.sv
// ----------------------------------------------------------------------------
// lqr_ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module lqr_ram #(
  parameter int DEPTH = lqr_pkg::DEPTH_DEF,
  parameter int WIDTH = lqr_pkg::VALUE_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/lqr_ctrl.sv
// ----------------------------------------------------------------------------
// lqr_ctrl
// sequencer, list pointers, slot allocator and the shared value compare
// ----------------------------------------------------------------------------
module lqr_ctrl #(
  parameter int DEPTH       = lqr_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = lqr_pkg::VALUE_WIDTH_DEF,
  localparam int SLOT_W     = $clog2(DEPTH),
  localparam int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  lqr_pkg::lqr_mode_t     mode_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   busy_o,
  output lqr_pkg::lqr_res_t      res_o,
  output logic [VALUE_WIDTH-1:0] head_val_o,
  output logic [VALUE_WIDTH-1:0] tail_val_o,
  output logic [CNT_W-1:0]       count_o
);

  lqr_pkg::lqr_state_e  state_q, state_d;
  lqr_pkg::lqr_status_e status_q, status_d;

  logic [SLOT_W-1:0]      head_q, head_d, tail_q, tail_d;
  logic [SLOT_W-1:0]      prev_q, prev_d, cur_q, cur_d;
  logic [CNT_W-1:0]       count_q, count_d, idx_q, idx_d;
  logic [CNT_W-1:0]       fresh_q, fresh_d, ftop_q, ftop_d;
  logic [VALUE_WIDTH-1:0] head_val_q, head_val_d, tail_val_q, tail_val_d;
  logic [VALUE_WIDTH-1:0] prev_val_q, prev_val_d, val_q, val_d;
  lqr_pkg::lqr_mode_t     mode_q, mode_d;

  logic                   ent_we, lnk_we, fre_we;
  logic [SLOT_W-1:0]      ent_waddr, lnk_waddr, fre_waddr;
  logic [SLOT_W-1:0]      ent_raddr, lnk_raddr, fre_raddr;
  logic [VALUE_WIDTH-1:0] ent_wdata, ent_rdata;
  logic [SLOT_W-1:0]      lnk_wdata, lnk_rdata, fre_wdata, fre_rdata;

  logic                   hit;
  logic [SLOT_W-1:0]      slot;

  lqr_ram #(.DEPTH(DEPTH), .WIDTH(VALUE_WIDTH)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  lqr_ram #(.DEPTH(DEPTH), .WIDTH(SLOT_W)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (lnk_waddr),
    .wdata_i (lnk_wdata),
    .raddr_i (lnk_raddr),
    .rdata_o (lnk_rdata)
  );

  // stack of released slots, slots never used come from fresh_q
  lqr_ram #(.DEPTH(DEPTH), .WIDTH(SLOT_W)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fre_we),
    .waddr_i (fre_waddr),
    .wdata_i (fre_wdata),
    .raddr_i (fre_raddr),
    .rdata_o (fre_rdata)
  );

  // shared compare unit
  assign hit  = (ent_rdata == val_q);
  assign slot = (ftop_q != '0) ? fre_rdata : fresh_q[SLOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lqr_pkg::S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      fresh_q <= '0;
      ftop_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      fresh_q <= fresh_d;
      ftop_q  <= ftop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    prev_q     <= prev_d;
    cur_q      <= cur_d;
    idx_q      <= idx_d;
    head_val_q <= head_val_d;
    tail_val_q <= tail_val_d;
    prev_val_q <= prev_val_d;
    val_q      <= val_d;
    mode_q     <= mode_d;
  end

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    head_d     = head_q;
    tail_d     = tail_q;
    prev_d     = prev_q;
    cur_d      = cur_q;
    count_d    = count_q;
    idx_d      = idx_q;
    fresh_d    = fresh_q;
    ftop_d     = ftop_q;
    head_val_d = head_val_q;
    tail_val_d = tail_val_q;
    prev_val_d = prev_val_q;
    val_d      = val_q;
    mode_d     = mode_q;
    ent_we     = 1'b0;
    ent_waddr  = slot;
    ent_wdata  = val_q;
    ent_raddr  = '0;
    lnk_we     = 1'b0;
    lnk_waddr  = '0;
    lnk_wdata  = '0;
    lnk_raddr  = '0;
    fre_we     = 1'b0;
    fre_waddr  = ftop_q[SLOT_W-1:0];
    fre_wdata  = head_q;
    fre_raddr  = SLOT_W'(ftop_q - 1'b1);
    res_o      = '{valid: 1'b0, status: status_q};

    case (state_q)
      lqr_pkg::S_IDLE: begin
        lnk_raddr = head_q;
        if (start_i) begin
          mode_d   = mode_i;
          val_d    = value_i;
          status_d = lqr_pkg::STAT_OK;
          state_d  = lqr_pkg::S_DONE;
          case (mode_i)
            lqr_pkg::MODE_PUSH_TAIL, lqr_pkg::MODE_PUSH_HEAD: begin
              if (value_i == '0) begin
                status_d = lqr_pkg::STAT_ZERO;
              end else if (count_q == CNT_W'(DEPTH)) begin
                status_d = lqr_pkg::STAT_FULL;
              end else begin
                state_d = lqr_pkg::S_PUSH;
              end
            end
            lqr_pkg::MODE_POP, lqr_pkg::MODE_REMOVE: begin
              if (count_q == '0) begin
                status_d = (mode_i == lqr_pkg::MODE_POP) ? lqr_pkg::STAT_EMPTY
                                                         : lqr_pkg::STAT_NOT_FOUND;
              end else if (mode_i == lqr_pkg::MODE_POP || head_val_q == value_i) begin
                if (count_q == CNT_W'(1)) begin
                  // last entry leaves, pointers return to their reset values
                  fre_we  = 1'b1;
                  ftop_d  = ftop_q + 1'b1;
                  head_d  = '0;
                  tail_d  = '0;
                  count_d = '0;
                end else begin
                  state_d = lqr_pkg::S_POP_NEXT;
                end
              end else if (count_q == CNT_W'(1)) begin
                status_d = lqr_pkg::STAT_NOT_FOUND;
              end else begin
                prev_d     = head_q;
                prev_val_d = head_val_q;
                idx_d      = CNT_W'(1);
                state_d    = lqr_pkg::S_WALK_NEXT;
              end
            end
            lqr_pkg::MODE_CLEAR: begin
              head_d  = '0;
              tail_d  = '0;
              count_d = '0;
              fresh_d = '0;
              ftop_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end

      lqr_pkg::S_PUSH: begin
        ent_we = 1'b1;
        if (ftop_q != '0) begin
          ftop_d = ftop_q - 1'b1;
        end else begin
          fresh_d = fresh_q + 1'b1;
        end
        if (mode_q == lqr_pkg::MODE_PUSH_HEAD) begin
          lnk_we     = 1'b1;
          lnk_waddr  = slot;
          lnk_wdata  = head_q;
          head_d     = slot;
          head_val_d = val_q;
          if (count_q == '0) begin
            tail_d     = slot;
            tail_val_d = val_q;
          end
        end else begin
          if (count_q != '0) begin
            lnk_we    = 1'b1;
            lnk_waddr = tail_q;
            lnk_wdata = slot;
          end else begin
            head_d     = slot;
            head_val_d = val_q;
          end
          tail_d     = slot;
          tail_val_d = val_q;
        end
        count_d = count_q + 1'b1;
        state_d = lqr_pkg::S_DONE;
      end

      lqr_pkg::S_POP_NEXT: begin
        ent_raddr = lnk_rdata;
        fre_we    = 1'b1;
        ftop_d    = ftop_q + 1'b1;
        head_d    = lnk_rdata;
        count_d   = count_q - 1'b1;
        state_d   = lqr_pkg::S_POP_VAL;
      end

      lqr_pkg::S_POP_VAL: begin
        head_val_d = ent_rdata;
        state_d    = lqr_pkg::S_DONE;
      end

      lqr_pkg::S_WALK_NEXT: begin
        cur_d     = lnk_rdata;
        ent_raddr = lnk_rdata;
        lnk_raddr = lnk_rdata;
        state_d   = lqr_pkg::S_WALK_CMP;
      end

      lqr_pkg::S_WALK_CMP: begin
        // lnk_rdata holds the link of cur here
        if (hit) begin
          lnk_we    = 1'b1;
          lnk_waddr = prev_q;
          lnk_wdata = lnk_rdata;
          if (cur_q == tail_q) begin
            tail_d     = prev_q;
            tail_val_d = prev_val_q;
          end
          fre_we    = 1'b1;
          fre_wdata = cur_q;
          ftop_d    = ftop_q + 1'b1;
          count_d   = count_q - 1'b1;
          state_d   = lqr_pkg::S_DONE;
        end else if (CNT_W'(idx_q + 1'b1) == count_q) begin
          status_d = lqr_pkg::STAT_NOT_FOUND;
          state_d  = lqr_pkg::S_DONE;
        end else begin
          prev_d     = cur_q;
          prev_val_d = ent_rdata;
          idx_d      = idx_q + 1'b1;
          cur_d      = lnk_rdata;
          ent_raddr  = lnk_rdata;
          lnk_raddr  = lnk_rdata;
        end
      end

      lqr_pkg::S_DONE: begin
        res_o   = '{valid: 1'b1, status: status_q};
        state_d = lqr_pkg::S_IDLE;
      end

      default: begin
        state_d = lqr_pkg::S_IDLE;
      end
    endcase
  end

  assign busy_o     = (state_q != lqr_pkg::S_IDLE);
  assign head_val_o = head_val_q;
  assign tail_val_o = tail_val_q;
  assign count_o    = count_q;

endmodule

>>> rtl/linked_queue_with_remove_top.sv
// ----------------------------------------------------------------------------
// linked_queue_with_remove_top
// bounded linked queue of tags with push, pop, remove by value and clear
// ----------------------------------------------------------------------------
// usage:
//   a command is taken at a clock edge with start_i high and busy_o low;
//   mode_i selects push tail, push head, pop head, remove by value or clear
//   and value_i carries the tag. busy_o stays high while the command runs.
//   each command gives one result transaction: done_o is high for exactly
//   one cycle with status, head and tail values and the entry count.
//   path to done_o: errors, clear and single entry pops go straight to the
//   done state, pushes pass the push state, pops and head removes pass the
//   pop next and pop value states, and a remove beyond the head passes the
//   walk next and walk compare states; the result is then registered onto
//   done_o. a new command can be accepted in the cycle done_o is high. a
//   remove walks the list one entry per cycle through the single value comparator.
//   reset empties the queue at once, with no sweep of the slot memories.
//   the receiver has no stall: each result must be taken when done_o is high.
// ----------------------------------------------------------------------------
`include "linked_queue_with_remove_top_defines.svh"

module linked_queue_with_remove_top #(
  parameter int DEPTH       = lqr_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = lqr_pkg::VALUE_WIDTH_DEF,
  localparam int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [lqr_pkg::MODE_W-1:0]   mode_i,
  input  logic [VALUE_WIDTH-1:0]       value_i,
  output logic                         done_o,
  output logic [lqr_pkg::STATUS_W-1:0] status_o,
  output logic [lqr_pkg::OUT_W-1:0]    head_value_o,
  output logic [lqr_pkg::OUT_W-1:0]    tail_value_o,
  output logic [CNT_W-1:0]             entry_total_o
);

  lqr_pkg::lqr_res_t       res;
  logic [VALUE_WIDTH-1:0]  head_val, tail_val;
  logic [CNT_W-1:0]        count;
  logic [lqr_pkg::OUT_W-1:0] head_out, tail_out;

  logic                         done_q;
  logic [lqr_pkg::STATUS_W-1:0] status_q;
  logic [lqr_pkg::OUT_W-1:0]    head_value_q, tail_value_q;
  logic [CNT_W-1:0]             entry_total_q;

  lqr_ctrl #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .mode_i     (mode_i),
    .value_i    (value_i),
    .busy_o     (busy_o),
    .res_o      (res),
    .head_val_o (head_val),
    .tail_val_o (tail_val),
    .count_o    (count)
  );

  if (VALUE_WIDTH >= lqr_pkg::OUT_W) begin : g_trunc
    assign head_out = head_val[lqr_pkg::OUT_W-1:0];
    assign tail_out = tail_val[lqr_pkg::OUT_W-1:0];
  end else begin : g_ext
    assign head_out = {{(lqr_pkg::OUT_W - VALUE_WIDTH){1'b0}}, head_val};
    assign tail_out = {{(lqr_pkg::OUT_W - VALUE_WIDTH){1'b0}}, tail_val};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res.valid;
    end
  end

  // stored values are stale once the queue is empty, report zero instead
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      status_q      <= res.status;
      head_value_q  <= (count != '0) ? head_out : '0;
      tail_value_q  <= (count != '0) ? tail_out : '0;
      entry_total_q <= count;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign head_value_o  = head_value_q;
  assign tail_value_o  = tail_value_q;
  assign entry_total_o = entry_total_q;

  `LQR_ASSERT_IMP(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, ##1 busy_o)
  `LQR_ASSERT_IMP(a_done_single, clk_i, rst_ni, done_o, ##1 !done_o)
  `LQR_ASSERT_IMP(a_full_count, clk_i, rst_ni, done_o && status_o == lqr_pkg::STAT_FULL, entry_total_o == CNT_W'(DEPTH))
  `LQR_ASSERT_IMP(a_empty_zero, clk_i, rst_ni, done_o && entry_total_o == '0, head_value_o == '0 && tail_value_o == '0)

endmodule
